### hdl/b64d_pkg.sv
// Shared types, constants and the alphabet lookup for the base64 stream decoder.
`default_nettype none

package b64d_pkg;

  // Padding character and the default depth of the job queue
  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam int unsigned JOB_QUEUE_DEPTH = 4;

  // One accepted character
  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_item_t;

  // One delivered result
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       end_of_message;
    logic       bad_padding;
    logic       last_of_run;
  } out_item_t;

  // All results caused by one character: bytes first, then the optional status
  typedef struct packed {
    logic [2:0][7:0] data;    // data[0] goes out first
    logic [1:0]      nbytes;  // 0..3 data bytes
    logic            status;  // end-of-message status follows the bytes
    logic            bad;     // error flag carried by the status
  } job_t;

  // Alphabet lookup result
  typedef struct packed {
    logic       hit;
    logic [5:0] value;
  } sextet_t;

  // Standard alphabet: A-Z, a-z, 0-9, '+', '/'; anything else misses
  function automatic sextet_t sextet_of(input logic [7:0] ch);
    sextet_t s;
    s.hit   = 1'b1;
    s.value = '0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s.value = 6'(ch - 8'h41);
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s.value = 6'(ch - 8'h61 + 8'd26);
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s.value = 6'(ch - 8'h30 + 8'd52);
    end else if (ch == 8'h2B) begin
      s.value = 6'd62;
    end else if (ch == 8'h2F) begin
      s.value = 6'd63;
    end else begin
      s.hit = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

### hdl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, job queue and result sequencer.
// A character's job is written into the job queue registers; its results reach the result ports from the queue head.
// Throughput: one character per cycle while the job queue has room; results leave at one
// per cycle while pop is held, so a character's run of up to four results sets the drain rate of the queue.
// Each character that causes results takes one job queue slot until its last result is popped.
// Reset (rst, synchronous) clears the group state, the job queue and the result cursor.
`default_nettype none

module base64_stream_decoder
  import b64d_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = JOB_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  output logic           full,
  input  wire in_item_t  item,
  output logic           empty,
  input  wire logic      pop,
  output out_item_t      result
);

  logic accept;
  logic job_push;
  job_t job;
  logic head_valid;
  job_t head_job;
  logic head_pop;

  assign accept = push && !full;

  b64d_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job)
  );

  b64d_job_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (job_push),
    .push_job   (job),
    .full       (full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_job   (head_job),
    .head_pop   (head_pop),
    .pop        (pop),
    .empty      (empty),
    .result     (result)
  );

endmodule

`default_nettype wire

### hdl/b64d_front.sv
// Front end: maps characters to sextets, keeps the group state and builds a job for each item that causes results.
`default_nettype none

module b64d_front
  import b64d_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     accept,
  input  wire in_item_t item,
  output logic          job_push,
  output job_t          job
);

  logic [17:0] sextet_bits, sextet_bits_next;
  logic [1:0]  sextet_count, sextet_count_next;
  logic        padding_seen, padding_seen_next;
  logic        error_seen, error_seen_next;
  sextet_t     sx;
  logic [23:0] group;

  assign sx    = sextet_of(item.in_char);
  assign group = {sextet_bits, sx.value};

  // Decode one character and work out the results it causes
  always_comb begin
    sextet_bits_next  = sextet_bits;
    sextet_count_next = sextet_count;
    padding_seen_next = padding_seen;
    error_seen_next   = error_seen;
    job               = '0;
    job_push          = 1'b0;
    if (accept) begin
      if (!padding_seen) begin
        if (item.in_char == PAD_CHAR) begin
          // flush the partial group
          unique case (sextet_count)
            2'd0: ;
            2'd1: error_seen_next = 1'b1;
            2'd2: begin
              job.data[0] = sextet_bits[11:4];
              job.nbytes  = 2'd1;
            end
            2'd3: begin
              job.data[0] = sextet_bits[17:10];
              job.data[1] = sextet_bits[9:2];
              job.nbytes  = 2'd2;
            end
          endcase
          padding_seen_next = 1'b1;
          sextet_bits_next  = '0;
          sextet_count_next = '0;
        end else if (sx.hit) begin
          if (sextet_count == 2'd3) begin
            job.data[0]       = group[23:16];
            job.data[1]       = group[15:8];
            job.data[2]       = group[7:0];
            job.nbytes        = 2'd3;
            sextet_bits_next  = '0;
            sextet_count_next = '0;
          end else begin
            sextet_bits_next  = group[17:0];
            sextet_count_next = sextet_count + 2'd1;
          end
        end
      end
      // closing item: status result, then back to the reset state
      if (item.end_of_input) begin
        job.status        = 1'b1;
        job.bad           = error_seen_next;
        sextet_bits_next  = '0;
        sextet_count_next = '0;
        padding_seen_next = 1'b0;
        error_seen_next   = 1'b0;
      end
      job_push = (job.nbytes != 2'd0) || job.status;
    end
  end

  // Group state
  always_ff @(posedge clk) begin
    if (rst) begin
      sextet_bits  <= '0;
      sextet_count <= '0;
      padding_seen <= 1'b0;
      error_seen   <= 1'b0;
    end else begin
      sextet_bits  <= sextet_bits_next;
      sextet_count <= sextet_count_next;
      padding_seen <= padding_seen_next;
      error_seen   <= error_seen_next;
    end
  end

  // A closing item leaves the decoder clean for the next message
  a_eom_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && item.end_of_input) |=>
      (sextet_count == 2'd0 && !padding_seen && !error_seen && sextet_bits == '0))
    else $error("state not cleared after end of message");

endmodule

`default_nettype wire

### hdl/b64d_job_queue.sv
// Short queue of jobs between the front end and the result sequencer.
`default_nettype none

module b64d_job_queue
  import b64d_pkg::*;
#(
  parameter int unsigned DEPTH = JOB_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("job queue overfilled");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !full && !pop) |=> (count == CW'($past(count) + 1'b1)))
    else $error("job queue lost a push");

endmodule

`default_nettype wire

### hdl/b64d_back.sv
// Back end: steps through the results of the head job, one per pop.
`default_nettype none

module b64d_back
  import b64d_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic head_valid,
  input  wire job_t head_job,
  output logic      head_pop,
  input  wire logic pop,
  output logic      empty,
  output out_item_t result
);

  logic [1:0] idx;
  logic [2:0] total;
  logic       is_last;
  logic       take;

  assign total   = {1'b0, head_job.nbytes} + {2'b00, head_job.status};
  assign is_last = (({1'b0, idx} + 3'd1) == total);
  assign empty   = !head_valid;
  assign take    = pop && head_valid;
  assign head_pop = take && is_last;

  // Result under the cursor: bytes first, status last
  always_comb begin
    result             = '0;
    result.last_of_run = is_last;
    if ({1'b0, idx} < {1'b0, head_job.nbytes}) begin
      result.byte_valid = 1'b1;
      unique case (idx)
        2'd0:    result.out_byte = head_job.data[0];
        2'd1:    result.out_byte = head_job.data[1];
        2'd2:    result.out_byte = head_job.data[2];
        default: result.out_byte = '0;
      endcase
    end else begin
      result.end_of_message = 1'b1;
      result.bad_padding    = head_job.bad;
    end
  end

  // Cursor within the head job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  a_cursor_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> ({1'b0, idx} < total))
    else $error("result cursor past end of job");

  a_cursor_steps: assert property (@(posedge clk) disable iff (rst)
    (take && !is_last) |=> (idx == $past(idx) + 2'd1))
    else $error("result cursor skipped");

endmodule

`default_nettype wire
